// ===== src/irrigation_mode_controller_assert.svh =====
// assertion macros for the irrigation mode controller
// used by irrigation_mode_controller.sv, no other dependencies
`ifndef IRRIGATION_MODE_CONTROLLER_ASSERT_SVH
`define IRRIGATION_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irrigation mode controller check failed");

// next-cycle implication, disabled in reset
`define IMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irrigation mode controller check failed");

`endif

// ===== src/imc_pkg.sv =====
// shared types and codes for the irrigation mode controller
// no dependencies
package imc_pkg;

    localparam int unsigned TIME_W  = 17;
    localparam int unsigned DAY_W   = 3;
    localparam int unsigned MOIST_W = 8;
    localparam int unsigned DAYS_W  = 7;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        KEY_IDLE    = 2'd0,
        KEY_PRESSED = 2'd1,
        KEY_HANDLED = 2'd2
    } t_key_phase;

    localparam logic [CODE_W-1:0] DISP_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] DISP_FORWARD  = 2'd1;
    localparam logic [CODE_W-1:0] DISP_BACKWARD = 2'd2;

    localparam logic [CODE_W-1:0] MODE_ANN_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] MODE_ANN_MANUAL = 2'd1;
    localparam logic [CODE_W-1:0] MODE_ANN_AUTO   = 2'd2;

    localparam logic [CODE_W-1:0] WATER_ANN_NONE    = 2'd0;
    localparam logic [CODE_W-1:0] WATER_ANN_STARTED = 2'd1;
    localparam logic [CODE_W-1:0] WATER_ANN_STOPPED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WATERING_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATERING_DAYS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1_STOP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN2_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN2_STOP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOIST_LOWER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MOIST_UPPER   = 3'd7;

    localparam logic [DAY_W-1:0] WDAY_SUNDAY     = 3'd0;
    localparam logic [DAY_W-1:0] DAY_BIT_SUNDAY  = 3'd6;

    function automatic t_key_phase key_track(input logic level, input t_key_phase phase);
        t_key_phase res;
        if (level) begin
            res = KEY_IDLE;
        end else if (phase == KEY_IDLE) begin
            res = KEY_PRESSED;
        end else begin
            res = phase;
        end
        return res;
    endfunction

    function automatic logic in_window(input logic [TIME_W-1:0] start,
                                       input logic [TIME_W-1:0] stop,
                                       input logic [TIME_W-1:0] now);
        return (start != stop) && (start <= now) && (now < stop);
    endfunction

endpackage

// ===== src/irrigation_mode_controller.sv =====
// irrigation mode controller top level: key handling, mode and pump control
// depends on imc_pkg and irrigation_mode_controller_assert.svh
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+--------------------------------
//  tick in  | in        | i_valid / o_stall   | time, weekday, moisture, keys
//  result   | out       | o_valid / i_stall   | pump, mode, display, announces
//  config   | in        | i_cfg_valid / ready | register index, write data
//
// one tick per cycle unless the result stalls; path: input register, result register
// the key phases, mode and pump state update as a word moves into the result register
// a stalled result holds while one more tick waits in the input register
// reset (synchronous, active low) clears state and all configuration to zero
// configuration is always ready and never stalls a write
`include "irrigation_mode_controller_assert.svh"

module irrigation_mode_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [imc_pkg::TIME_W-1:0]        i_time_of_day,
    input  logic [imc_pkg::DAY_W-1:0]         i_weekday,
    input  logic [imc_pkg::MOIST_W-1:0]       i_soil_moisture,
    input  logic                              i_key_one_level,
    input  logic                              i_key_two_level,
    input  logic                              i_key_three_level,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_pump_on,
    output logic                              o_manual_mode,
    output logic [imc_pkg::CODE_W-1:0]        o_display_step,
    output logic [imc_pkg::CODE_W-1:0]        o_mode_announce,
    output logic [imc_pkg::CODE_W-1:0]        o_watering_announce,
    output logic                              o_reset_request,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [imc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [imc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import imc_pkg::*;

    logic                r_cfg_mode;
    logic [DAYS_W-1:0]   r_cfg_days;
    logic [TIME_W-1:0]   r_cfg_w1_start;
    logic [TIME_W-1:0]   r_cfg_w1_stop;
    logic [TIME_W-1:0]   r_cfg_w2_start;
    logic [TIME_W-1:0]   r_cfg_w2_stop;
    logic [MOIST_W-1:0]  r_cfg_lower;
    logic [MOIST_W-1:0]  r_cfg_upper;

    logic                r_in_vld;
    logic [TIME_W-1:0]   r_in_time;
    logic [DAY_W-1:0]    r_in_wday;
    logic [MOIST_W-1:0]  r_in_moist;
    logic [2:0]          r_in_keys;

    t_key_phase          r_phase [3];
    logic                r_manual;
    logic                r_pump;

    logic                r_out_vld;
    logic [CODE_W-1:0]   r_out_disp;
    logic [CODE_W-1:0]   r_out_mode_ann;
    logic [CODE_W-1:0]   r_out_water_ann;
    logic                r_out_reset_req;

    t_key_phase          n_phase [3];
    logic                n_manual;
    logic                n_pump;
    logic [CODE_W-1:0]   n_disp;
    logic [CODE_W-1:0]   n_mode_ann;
    logic [CODE_W-1:0]   n_water_ann;
    logic                n_reset_req;

    logic                out_adv;
    logic                in_take;
    logic                cfg_wr;
    logic [2:0]          pressed;
    logic [DAY_W-1:0]    day_bit;
    logic                day_on;
    logic                win_hit;
    logic                pump_keys;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign out_adv     = !r_out_vld || !i_stall;
    assign o_stall     = r_in_vld && !out_adv;
    assign in_take     = i_valid && !o_stall;

    // key phases and key actions
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_phase[k] = key_track(r_in_keys[k], r_phase[k]);
            pressed[k] = (n_phase[k] == KEY_PRESSED);
        end
        n_manual    = r_manual;
        pump_keys   = r_pump;
        n_disp      = DISP_NONE;
        n_mode_ann  = MODE_ANN_NONE;
        n_reset_req = 1'b0;
        unique case (pressed)
            3'b001: begin
                n_phase[0] = KEY_HANDLED;
                n_disp     = DISP_FORWARD;
            end
            3'b010: begin
                n_phase[1] = KEY_HANDLED;
                n_manual   = !r_manual;
                n_mode_ann = !r_manual ? MODE_ANN_MANUAL : MODE_ANN_AUTO;
            end
            3'b100: begin
                n_phase[2] = KEY_HANDLED;
                if (!r_manual) begin
                    n_disp = DISP_BACKWARD;
                end else begin
                    pump_keys = !r_pump;
                end
            end
            3'b111: begin
                n_phase[0]  = KEY_HANDLED;
                n_phase[1]  = KEY_HANDLED;
                n_phase[2]  = KEY_HANDLED;
                n_reset_req = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // automatic pump control
    assign day_bit = (r_in_wday == WDAY_SUNDAY) ? DAY_BIT_SUNDAY : r_in_wday - 3'd1;
    assign day_on  = r_cfg_days[day_bit];
    assign win_hit = in_window(r_cfg_w1_start, r_cfg_w1_stop, r_in_time)
                  || in_window(r_cfg_w2_start, r_cfg_w2_stop, r_in_time);

    always_comb begin
        n_pump = pump_keys;
        if (!n_manual) begin
            if (!r_cfg_mode && day_on) begin
                n_pump = win_hit;
            end else if (r_cfg_mode && (r_cfg_lower != r_cfg_upper)) begin
                if (r_cfg_upper <= r_in_moist) begin
                    n_pump = 1'b0;
                end else if (r_in_moist <= r_cfg_lower) begin
                    n_pump = 1'b1;
                end
            end
        end
        if (n_pump == r_pump) begin
            n_water_ann = WATER_ANN_NONE;
        end else if (n_pump) begin
            n_water_ann = WATER_ANN_STARTED;
        end else begin
            n_water_ann = WATER_ANN_STOPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode     <= 1'b0;
            r_cfg_days     <= '0;
            r_cfg_w1_start <= '0;
            r_cfg_w1_stop  <= '0;
            r_cfg_w2_start <= '0;
            r_cfg_w2_stop  <= '0;
            r_cfg_lower    <= '0;
            r_cfg_upper    <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_WATERING_MODE: r_cfg_mode     <= i_cfg_data[0];
                CFG_WATERING_DAYS: r_cfg_days     <= i_cfg_data[DAYS_W-1:0];
                CFG_WIN1_START:    r_cfg_w1_start <= i_cfg_data[TIME_W-1:0];
                CFG_WIN1_STOP:     r_cfg_w1_stop  <= i_cfg_data[TIME_W-1:0];
                CFG_WIN2_START:    r_cfg_w2_start <= i_cfg_data[TIME_W-1:0];
                CFG_WIN2_STOP:     r_cfg_w2_stop  <= i_cfg_data[TIME_W-1:0];
                CFG_MOIST_LOWER:   r_cfg_lower    <= i_cfg_data[MOIST_W-1:0];
                CFG_MOIST_UPPER:   r_cfg_upper    <= i_cfg_data[MOIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (out_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_time  <= i_time_of_day;
            r_in_wday  <= i_weekday;
            r_in_moist <= i_soil_moisture;
            r_in_keys  <= {i_key_three_level, i_key_two_level, i_key_one_level};
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_manual  <= 1'b0;
            r_pump    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_phase[k] <= KEY_IDLE;
            end
        end else if (out_adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_manual <= n_manual;
                r_pump   <= n_pump;
                for (int k = 0; k < 3; k++) begin
                    r_phase[k] <= n_phase[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_vld) begin
            r_out_disp      <= n_disp;
            r_out_mode_ann  <= n_mode_ann;
            r_out_water_ann <= n_water_ann;
            r_out_reset_req <= n_reset_req;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_pump_on           = r_pump;
    assign o_manual_mode       = r_manual;
    assign o_display_step      = r_out_disp;
    assign o_mode_announce     = r_out_mode_ann;
    assign o_watering_announce = r_out_water_ann;
    assign o_reset_request     = r_out_reset_req;

    `IMC_ASSERT_NOW(a_water_ann_matches_pump, i_clk, i_rst_n,
        o_valid && (o_watering_announce != WATER_ANN_NONE),
        o_pump_on == (o_watering_announce == WATER_ANN_STARTED))
    `IMC_ASSERT_NOW(a_mode_ann_matches_mode, i_clk, i_rst_n,
        o_valid && (o_mode_announce != MODE_ANN_NONE),
        o_manual_mode == (o_mode_announce == MODE_ANN_MANUAL))
    `IMC_ASSERT_NOW(a_reset_req_alone, i_clk, i_rst_n,
        o_valid && o_reset_request,
        (o_display_step == DISP_NONE) && (o_mode_announce == MODE_ANN_NONE))
    `IMC_ASSERT_NEXT(a_state_held_without_word, i_clk, i_rst_n,
        !r_in_vld,
        (r_pump == $past(r_pump)) && (r_manual == $past(r_manual)))

endmodule
